/* src/blist_pkg.sv */
// shared types, sizes and command/status structs for the bounded list engine
package blist_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;

  // fixed field widths at the ports
  localparam int POS_BITS   = 5;
  localparam int COUNT_BITS = 5;
  localparam int DATA_BITS  = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_APPEND     = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_INSERT_AT  = 3'd4,
    REQ_DELETE_AT  = 3'd5,
    REQ_DUMP       = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    RD_AT,
    RD_BELOW,
    RD_ABOVE
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_VALUE
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    logic    emit;
    status_t emit_status;
    logic    emit_data;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic cnt_zero;
    logic cnt_full;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic idx_at_pos;
    logic idx_last;
    logic out_free;
  } stat_t;

endpackage

/* src/blist_dp.sv */
// datapath: request registers, entry memory, count, index and result register
module blist_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  blist_pkg::cmd_t                 cmd,
  output blist_pkg::stat_t                stat,
  input  logic [2:0]                      req_type,
  input  logic signed [blist_pkg::DATA_BITS-1:0] item_value,
  input  logic [blist_pkg::POS_BITS-1:0]  position,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [1:0]                      status,
  output logic [blist_pkg::COUNT_BITS-1:0] entry_count,
  output logic                            is_empty,
  output logic signed [blist_pkg::DATA_BITS-1:0] read_value,
  output logic                            last
);
  import blist_pkg::*;

  logic [2:0]            req_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [POS_W-1:0]      pos_r;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      rd_full;
  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rdata;
  logic [CNT_W:0]        idx_plus;

  // request capture, effective position chosen per request kind
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= req_type;
      value_r <= VALUE_BITS'(item_value);
      case (req_t'(req_type))
        REQ_PUSH_FRONT, REQ_POP_FRONT: pos_r <= '0;
        REQ_APPEND:                    pos_r <= POS_W'(count);
        default:                       pos_r <= POS_W'(position);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: count <= count + CNT_W'(1);
        CNT_DEC: count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (cmd.idx_op)
        IDX_COUNT: idx <= count;
        IDX_POS:   idx <= CNT_W'(pos_r);
        IDX_ZERO:  idx <= '0;
        IDX_INC:   idx <= idx + CNT_W'(1);
        IDX_DEC:   idx <= idx - CNT_W'(1);
        default:   idx <= idx;
      endcase
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_BELOW: rd_full = idx - CNT_W'(1);
      RD_ABOVE: rd_full = idx + CNT_W'(1);
      default:  rd_full = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.wr_op)
      WR_SHIFT: mem[idx[IDX_W-1:0]] <= rdata;
      WR_VALUE: mem[idx[IDX_W-1:0]] <= value_r;
      default: ;
    endcase
    if (cmd.rd_en) begin
      rdata <= mem[rd_full[IDX_W-1:0]];
    end
  end

  assign idx_plus = (CNT_W + 1)'(idx) + (CNT_W + 1)'(1);

  always_comb begin
    stat.req        = req_t'(req_r);
    stat.cnt_zero   = (count == '0);
    stat.cnt_full   = (count == CNT_W'(CAPACITY));
    stat.pos_gt_cnt = (pos_r > POS_W'(count));
    stat.pos_ge_cnt = (pos_r >= POS_W'(count));
    stat.idx_at_pos = (POS_W'(idx) == pos_r);
    stat.idx_last   = (idx_plus >= (CNT_W + 1)'(count));
    stat.out_free   = !out_valid || !out_stall;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= cmd.emit_status;
      entry_count <= COUNT_BITS'(count);
      is_empty    <= (count == '0);
      read_value  <= cmd.emit_data ? DATA_BITS'(rdata) : '0;
      last        <= cmd.emit_last;
    end
  end

endmodule

/* src/blist_ctrl.sv */
// controller: sequences each request over the datapath
module blist_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  blist_pkg::stat_t stat,
  output blist_pkg::cmd_t  cmd
);
  import blist_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR,
    S_REPLY,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  state_t  state, state_next;
  status_t st_r, st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      st_r  <= ST_OK;
    end else begin
      state <= state_next;
      st_r  <= st_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    st_next         = st_r;
    cmd.load        = 1'b0;
    cmd.idx_op      = IDX_HOLD;
    cmd.rd_en       = 1'b0;
    cmd.rd_sel      = RD_AT;
    cmd.wr_op       = WR_NONE;
    cmd.cnt_op      = CNT_HOLD;
    cmd.emit        = 1'b0;
    cmd.emit_status = st_r;
    cmd.emit_data   = 1'b0;
    cmd.emit_last   = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        st_next = ST_OK;
        case (stat.req)
          REQ_PUSH_FRONT, REQ_APPEND: begin
            if (stat.cnt_full) begin
              st_next    = ST_FULL;
              state_next = S_REPLY;
            end else begin
              cmd.idx_op = IDX_COUNT;
              state_next = S_INS_CHK;
            end
          end
          REQ_INSERT_AT: begin
            if (stat.pos_gt_cnt) begin
              st_next    = ST_BAD_POS;
              state_next = S_REPLY;
            end else if (stat.cnt_full) begin
              st_next    = ST_FULL;
              state_next = S_REPLY;
            end else begin
              cmd.idx_op = IDX_COUNT;
              state_next = S_INS_CHK;
            end
          end
          REQ_POP_FRONT: begin
            if (stat.cnt_zero) begin
              st_next    = ST_EMPTY;
              state_next = S_REPLY;
            end else begin
              cmd.idx_op = IDX_POS;
              state_next = S_DEL_CHK;
            end
          end
          REQ_POP_BACK: begin
            if (stat.cnt_zero) begin
              st_next = ST_EMPTY;
            end else begin
              cmd.cnt_op = CNT_DEC;
            end
            state_next = S_REPLY;
          end
          REQ_DELETE_AT: begin
            if (stat.cnt_zero) begin
              st_next    = ST_EMPTY;
              state_next = S_REPLY;
            end else if (stat.pos_ge_cnt) begin
              st_next    = ST_BAD_POS;
              state_next = S_REPLY;
            end else begin
              cmd.idx_op = IDX_POS;
              state_next = S_DEL_CHK;
            end
          end
          REQ_DUMP: begin
            if (stat.cnt_zero) begin
              st_next    = ST_EMPTY;
              state_next = S_REPLY;
            end else begin
              cmd.idx_op = IDX_ZERO;
              state_next = S_DUMP_RD;
            end
          end
          default: state_next = S_REPLY;
        endcase
      end
      S_INS_CHK: begin
        if (stat.idx_at_pos) begin
          cmd.wr_op  = WR_VALUE;
          cmd.cnt_op = CNT_INC;
          state_next = S_REPLY;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_BELOW;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_op  = WR_SHIFT;
        cmd.idx_op = IDX_DEC;
        state_next = S_INS_CHK;
      end
      S_DEL_CHK: begin
        if (stat.idx_last) begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_REPLY;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ABOVE;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_op  = WR_SHIFT;
        cmd.idx_op = IDX_INC;
        state_next = S_DEL_CHK;
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_AT;
        state_next = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_data   = 1'b1;
          cmd.emit_last   = stat.idx_last;
          if (stat.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_op = IDX_INC;
            state_next = S_DUMP_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/bounded_list_engine.sv */
// top level of the bounded list engine: controller plus datapath
//
// usage
//   request channel: in_valid / in_stall with req_type, item_value, position;
//   an item is taken on a clock edge with in_valid high and in_stall low
//   result channel: out_valid / out_stall with status, entry_count, is_empty,
//   read_value, last; every request gives one result, a dump of a non-empty
//   list gives one result per entry, front first, with last on the final one
// sequencing (p = position)
//   one item at a time; in_stall is high from acceptance until the final
//   result has been loaded into the output register
//   insert or push: entries from p to the back move up one place, one at a
//   time through the entry memory (read, then write); delete or pop front:
//   entries behind p move down the same way; pop back, unused code and
//   errors: no shift; dump: one memory read then one result per entry
// reset: rst (synchronous) empties the list and drops out_valid
// stall: a result holds in the output register while out_stall is high;
//   the sequencer waits for it to drain before loading the next one
module bounded_list_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [2:0]                            req_type,
  input  logic signed [blist_pkg::DATA_BITS-1:0] item_value,
  input  logic [blist_pkg::POS_BITS-1:0]        position,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            status,
  output logic [blist_pkg::COUNT_BITS-1:0]      entry_count,
  output logic                                  is_empty,
  output logic signed [blist_pkg::DATA_BITS-1:0] read_value,
  output logic                                  last
);
  import blist_pkg::*;

  cmd_t  cmd;   // controller to datapath
  stat_t stat;  // datapath conditions back to the controller

  blist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  blist_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req_type),
    .item_value  (item_value),
    .position    (position),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .read_value  (read_value),
    .last        (last)
  );

endmodule
